// ===== hdl/rmpa_pkg.sv =====
package rmpa_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int ID_W = 3;
    localparam int TIME_W = 12;
    localparam int PRIO_W = 4;
    localparam int SUM_W = 20;
    localparam int LIMIT_W = 16;
    localparam logic [SUM_W-1:0] ONE_Q16 = 20'h10000;
    localparam logic [LIMIT_W-1:0] UTIL_LIMIT_RESET = 16'd45875;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] period;
    } task_entry_t;

endpackage

// ===== hdl/rmpa_divider.sv =====
module rmpa_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rmpa_pkg::TIME_W-1:0] comp,
    input  logic [rmpa_pkg::TIME_W-1:0] period,
    output logic                        busy,
    output logic                        done,
    output logic [rmpa_pkg::SUM_W-1:0]  quotient
);
    import rmpa_pkg::*;

    // Restoring division of comp*65536 by period, one quotient bit per cycle.
    localparam int NUM_W = TIME_W + 16;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg, num_next;
    logic [TIME_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]  q_reg, q_next;
    logic [TIME_W-1:0] div_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TIME_W:0]   shifted;
    logic [TIME_W+1:0] trial;

    always_comb
    begin
        shifted = {rem_reg[TIME_W-1:0], num_reg[NUM_W-1]};
        trial = {1'b0, shifted} - {2'b00, div_reg};
        num_next = num_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = {comp, 16'h0000};
            rem_next = '0;
            q_next = '0;
            cnt_next = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (!trial[TIME_W+1])
            begin
                rem_next = trial[TIME_W:0];
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        if (start)
            div_reg <= period;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = (q_reg > NUM_W'(ONE_Q16)) ? ONE_Q16 : q_reg[SUM_W-1:0];

endmodule

// ===== hdl/rate_monotonic_priority_assign.sv =====
// Channel   Direction  Beat contents
// s_axis    in         tdata: task_id, comp_time, period; tuser: none; tlast: last_task
// m_axis    out        tdata: out_task_id, priority_res, schedulable; tlast: last_result
// apb       in/out     util_limit at byte address 0
//
// Each load waits for the bit-serial utilization divider (28 steps) to finish.
// After the last task, a selection sort over the task memory emits one result
// per task; each result scans all stored entries at one memory read a cycle.
// Reset clears the count and the sum and sets the limit to its reset value; the task memory is not cleared.
// Results wait in an output register while the sink stalls.
module rate_monotonic_priority_assign
#(
    parameter int MAX_TASKS = rmpa_pkg::MAX_TASKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // task_id [2:0], comp_time [14:3], period [26:15], zero fill to 32 bits
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tlast,
    // out_task_id [2:0], priority_res [6:3], schedulable [7]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rmpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [1:0] ADDR_LIMIT = 2'd0;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;

    // Task memory: id and period; written at one address, read at one address.
    task_entry_t mem [MAX_TASKS];
    task_entry_t rd_reg;

    logic [2:0]         state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               last_reg;
    // Emitted flags: one per entry.
    logic [MAX_TASKS-1:0] done_reg;
    logic [CNT_W-1:0]   emitted_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_addr_d_reg;
    logic               best_vld_reg;
    task_entry_t        best_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [PRIO_W-1:0]  prio_reg;
    logic [TIME_W-1:0]  prev_period_reg;
    logic               sched_reg;

    logic               in_acc, div_done, div_busy;
    logic [SUM_W-1:0]   div_q;
    logic [SUM_W:0]     sum_add;
    logic               wr_en;
    logic [IDX_W-1:0]   rd_addr;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign wr_en = in_acc && (count_reg < CNT_W'(MAX_TASKS));
    assign rd_addr = rd_idx_reg[IDX_W-1:0];
    assign sum_add = {1'b0, sum_reg} + {1'b0, div_q};
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LIMIT) ? {16'h0000, limit_reg} : 32'h0;

    rmpa_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (wr_en),
        .comp     (s_axis_tdata[14:3]),
        .period   (s_axis_tdata[26:15]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[IDX_W-1:0]] <= '{id: s_axis_tdata[2:0], period: s_axis_tdata[26:15]};
        rd_reg <= mem[rd_addr];
        rd_addr_d_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            sum_reg <= '0;
            limit_reg <= UTIL_LIMIT_RESET;
            last_reg <= 1'b0;
            done_reg <= '0;
            emitted_reg <= '0;
            rd_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            best_vld_reg <= 1'b0;
            best_reg <= '0;
            best_idx_reg <= '0;
            prev_period_reg <= '0;
            m_axis_tvalid <= 1'b0;
            prio_reg <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == ADDR_LIMIT)
                limit_reg <= pwdata[LIMIT_W-1:0];
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        last_reg <= s_axis_tlast;
                        if (wr_en)
                        begin
                            count_reg <= count_reg + 1'b1;
                            state_reg <= ST_DIV;
                        end
                        else if (s_axis_tlast)
                        begin
                            state_reg <= ST_SCAN;
                            rd_idx_reg <= '0;
                            rd_vld_reg <= 1'b0;
                            best_vld_reg <= 1'b0;
                            done_reg <= '0;
                            emitted_reg <= '0;
                            prio_reg <= '0;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        sum_reg <= (sum_add > {1'b0, ONE_Q16}) ? ONE_Q16 : sum_add[SUM_W-1:0];
                        if (last_reg)
                        begin
                            state_reg <= ST_SCAN;
                            rd_idx_reg <= '0;
                            rd_vld_reg <= 1'b0;
                            best_vld_reg <= 1'b0;
                            done_reg <= '0;
                            emitted_reg <= '0;
                            prio_reg <= '0;
                        end
                        else
                            state_reg <= ST_LOAD;
                    end
                end
                ST_SCAN:
                begin
                    // Issue reads over all stored entries; the pick is the
                    // longest period not yet emitted, earliest index on ties.
                    if (count_reg == '0)
                    begin
                        state_reg <= ST_LOAD;
                        sum_reg <= '0;
                    end
                    else
                    begin
                        if (rd_idx_reg < count_reg)
                        begin
                            rd_vld_reg <= 1'b1;
                            rd_idx_reg <= rd_idx_reg + 1'b1;
                        end
                        else
                            rd_vld_reg <= 1'b0;
                        if (rd_vld_reg && !done_reg[rd_addr_d_reg])
                        begin
                            if (!best_vld_reg || rd_reg.period > best_reg.period)
                            begin
                                best_vld_reg <= 1'b1;
                                best_reg <= rd_reg;
                                best_idx_reg <= rd_addr_d_reg;
                            end
                        end
                        if (!rd_vld_reg && rd_idx_reg == count_reg)
                            state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emitted_reg == '0 || best_reg.period != prev_period_reg)
                        prio_reg <= prio_reg + 1'b1;
                    prev_period_reg <= best_reg.period;
                    done_reg[best_idx_reg] <= 1'b1;
                    emitted_reg <= emitted_reg + 1'b1;
                    m_axis_tvalid <= 1'b1;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (m_axis_tready)
                    begin
                        m_axis_tvalid <= 1'b0;
                        rd_idx_reg <= '0;
                        rd_vld_reg <= 1'b0;
                        best_vld_reg <= 1'b0;
                        if (emitted_reg == count_reg)
                        begin
                            state_reg <= ST_LOAD;
                            count_reg <= '0;
                            sum_reg <= '0;
                        end
                        else
                            state_reg <= ST_SCAN;
                    end
                end
                default:
                    state_reg <= ST_LOAD;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN)
            sched_reg <= (sum_reg < {4'h0, limit_reg});
    end

    assign m_axis_tdata = {sched_reg, prio_reg, best_reg.id};
    assign m_axis_tlast = (emitted_reg == count_reg);

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("task count above capacity");
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= ONE_Q16)
        else $error("utilization sum above one");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !div_busy)
        else $error("divider busy during sort");

endmodule
